// ===== src/canonical_huffman_codec_assert.svh =====
// Assertion shorthands for the canonical Huffman codec.
// Each expects clk and rst_n in scope.
`ifndef CANONICAL_HUFFMAN_CODEC_ASSERT_SVH
`define CANONICAL_HUFFMAN_CODEC_ASSERT_SVH

// Same-cycle implication
`define CHC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("canonical_huffman_codec: same-cycle check failed");

// Next-cycle implication
`define CHC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("canonical_huffman_codec: next-cycle check failed");

`endif

// ===== src/chc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package chc_pkg;

  // Field widths
  localparam int OPC_W  = 3;
  localparam int LEN_W  = 5;
  localparam int CNT_W  = 9;
  localparam int IDX_W  = 9;
  localparam int SYM_W  = 9;
  localparam int KIND_W = 3;
  localparam int CODE_W = 16;
  localparam int SIZE_W = 5;

  // Input opcodes
  localparam logic [OPC_W-1:0] OPC_LOAD_COUNT  = 3'd0;
  localparam logic [OPC_W-1:0] OPC_LOAD_SYMBOL = 3'd1;
  localparam logic [OPC_W-1:0] OPC_BUILD       = 3'd2;
  localparam logic [OPC_W-1:0] OPC_DECODE      = 3'd3;
  localparam logic [OPC_W-1:0] OPC_ENCODE      = 3'd4;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_SYMBOL  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INVALID = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CODE    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NO_CODE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RANGE   = 3'd4;

  // Classified command passed from front to back
  typedef enum logic [2:0] {
    CMD_LOAD_COUNT,
    CMD_LOAD_SYMBOL,
    CMD_BUILD,
    CMD_DECODE,
    CMD_ENCODE,
    CMD_RANGE_ERR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [LEN_W-1:0]  code_length;
    logic [CNT_W-1:0]  length_count;
    logic [IDX_W-1:0]  table_index;
    logic [SYM_W-1:0]  symbol;
    logic              bit_in;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_BCLR,
    ST_BLEN,
    ST_BCODE,
    ST_BWR,
    ST_DEC_RD,
    ST_ENC_RD
  } eng_state_t;

endpackage
`default_nettype wire

// ===== src/chc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module chc_front #(
  parameter int SYMBOL_BITS     = 8,
  parameter int MAX_CODE_LENGTH = 16
) (
  input  logic [chc_pkg::OPC_W-1:0] opcode,
  input  logic [chc_pkg::LEN_W-1:0] code_length,
  input  logic [chc_pkg::CNT_W-1:0] length_count,
  input  logic [chc_pkg::IDX_W-1:0] table_index,
  input  logic [chc_pkg::SYM_W-1:0] symbol,
  input  logic                      bit_in,
  output logic                      keep,
  output chc_pkg::cmd_t             cmd
);
  import chc_pkg::*;

  localparam int NUM_SYMBOLS = (1 << SYMBOL_BITS) + 1;
  localparam int NUM_LENGTHS = MAX_CODE_LENGTH + 1;

  // Classify the item; range faults on loads are settled here
  always_comb begin
    cmd.code_length  = code_length;
    cmd.length_count = length_count;
    cmd.table_index  = table_index;
    cmd.symbol       = symbol;
    cmd.bit_in       = bit_in;
    cmd.op           = CMD_BUILD;
    keep             = 1'b1;
    unique case (opcode)
      OPC_LOAD_COUNT: begin
        cmd.op = (32'(code_length) >= 32'(NUM_LENGTHS)) ? CMD_RANGE_ERR : CMD_LOAD_COUNT;
      end
      OPC_LOAD_SYMBOL: begin
        cmd.op = (32'(table_index) >= 32'(NUM_SYMBOLS)) ? CMD_RANGE_ERR : CMD_LOAD_SYMBOL;
      end
      OPC_BUILD:  cmd.op = CMD_BUILD;
      OPC_DECODE: cmd.op = CMD_DECODE;
      OPC_ENCODE: cmd.op = CMD_ENCODE;
      // unused opcodes are taken and dropped
      default: keep = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/chc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module chc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  chc_pkg::cmd_t       push_data,
  input  logic                pop,
  output chc_pkg::cmd_t       head,
  output chc_pkg::fifo_stat_t stat
);
  import chc_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  // Two-entry queue between front and back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.empty = (cnt_r == 2'd0);
  assign stat.full  = (cnt_r == 2'd2);

endmodule
`default_nettype wire

// ===== src/chc_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
module chc_engine #(
  parameter int SYMBOL_BITS     = 8,
  parameter int MAX_CODE_LENGTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  chc_pkg::cmd_t              head,
  input  chc_pkg::fifo_stat_t        q_stat,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [chc_pkg::KIND_W-1:0] out_result_kind,
  output logic [chc_pkg::SYM_W-1:0]  out_symbol_out,
  output logic [chc_pkg::CODE_W-1:0] out_code_bits,
  output logic [chc_pkg::SIZE_W-1:0] out_code_size
);
  import chc_pkg::*;

  localparam int NUM_SYMBOLS = (1 << SYMBOL_BITS) + 1;
  localparam int NUM_LENGTHS = MAX_CODE_LENGTH + 1;
  localparam int AW          = $clog2(NUM_SYMBOLS);
  localparam int LAW         = $clog2(NUM_LENGTHS);
  localparam int LCW         = $clog2(NUM_LENGTHS + 1);
  localparam int OFW         = SYMBOL_BITS + 1;
  localparam logic [AW-1:0]  LAST_ADDR = AW'(NUM_SYMBOLS - 1);
  localparam logic [LCW-1:0] LEN_END   = LCW'(NUM_LENGTHS);
  localparam logic [LAW-1:0] BT_MAX    = LAW'(MAX_CODE_LENGTH);

  eng_state_t state_r, state_nxt;

  // Symbol memories: sorted list by table index, codes and sizes by symbol
  logic [SYM_W-1:0]  sorted_mem [NUM_SYMBOLS];
  logic [CODE_W-1:0] code_mem   [NUM_SYMBOLS];
  logic [SIZE_W-1:0] size_mem   [NUM_SYMBOLS];
  logic [SYM_W-1:0]  sorted_rd_r;
  logic [CODE_W-1:0] code_rd_r;
  logic [SIZE_W-1:0] size_rd_r;

  // Per-length tables
  logic [CNT_W-1:0]  counts_r [NUM_LENGTHS];
  logic [CODE_W-1:0] min_r    [NUM_LENGTHS];
  logic [CODE_W-1:0] max_r    [NUM_LENGTHS];

  logic              any_r, any_nxt;
  logic [CODE_W-1:0] acc_r, acc_nxt;
  logic [LAW-1:0]    bt_r, bt_nxt;
  logic [OFW-1:0]    off_r, off_nxt;
  logic [AW-1:0]     sweep_r, sweep_nxt;
  logic [LCW-1:0]    len_r, len_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [SYM_W-1:0]  osym_r, osym_nxt;
  logic [CODE_W-1:0] ocode_r, ocode_nxt;
  logic [SIZE_W-1:0] osize_r, osize_nxt;

  // Memory and table port controls
  logic              sym_we;
  logic [AW-1:0]     sym_wa, sym_ra;
  logic [SYM_W-1:0]  sym_wd;
  logic              cw_we;
  logic [AW-1:0]     cw_wa, cw_ra;
  logic [CODE_W-1:0] code_wd;
  logic [SIZE_W-1:0] size_wd;
  logic              cnt_we, mm_init, min_we, max_we;

  // Decoder datapath
  logic [CODE_W-1:0] acc_sh;
  logic [LAW-1:0]    bt_inc;
  logic [CNT_W-1:0]  cnt_len;
  logic              hit;
  logic [31:0]       idx_w;
  logic [OFW-1:0]    off_add;

  // Build datapath
  logic [LAW-1:0]    len_a;
  logic [CNT_W-1:0]  n_cur;
  logic              last_k;
  logic [CODE_W-1:0] code_inc;

  assign acc_sh  = {acc_r[CODE_W-2:0], head.bit_in};
  assign bt_inc  = bt_r + LAW'(1);
  assign cnt_len = counts_r[bt_inc];
  assign hit     = (acc_sh <= max_r[bt_inc]);
  assign idx_w   = 32'(off_r) + 32'(acc_sh) - 32'(min_r[bt_inc]);
  assign off_add = OFW'(32'(off_r) + 32'(cnt_len));

  assign len_a    = len_r[LAW-1:0];
  assign n_cur    = counts_r[len_a];
  assign last_k   = ((k_r + CNT_W'(1)) == n_cur);
  assign code_inc = code_r + CODE_W'(1);

  // State register and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      sweep_r     <= '0;
      any_r       <= 1'b0;
      acc_r       <= '0;
      bt_r        <= '0;
      off_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      any_r       <= any_nxt;
      acc_r       <= acc_nxt;
      bt_r        <= bt_nxt;
      off_r       <= off_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r   <= len_nxt;
    k_r     <= k_nxt;
    pos_r   <= pos_nxt;
    code_r  <= code_nxt;
    kind_r  <= kind_nxt;
    osym_r  <= osym_nxt;
    ocode_r <= ocode_nxt;
    osize_r <= osize_nxt;
  end

  // Per-length tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LENGTHS; i++) begin
        counts_r[i] <= '0;
        min_r[i]    <= '1;
        max_r[i]    <= '1;
      end
    end else begin
      if (cnt_we) counts_r[LAW'(head.code_length)] <= head.length_count;
      if (mm_init) begin
        for (int i = 0; i < NUM_LENGTHS; i++) begin
          min_r[i] <= '1;
          max_r[i] <= '1;
        end
      end else begin
        if (min_we) min_r[len_a] <= code_r;
        if (max_we) max_r[len_a] <= code_r;
      end
    end
  end

  // Memories, registered read
  always_ff @(posedge clk) begin
    if (sym_we) sorted_mem[sym_wa] <= sym_wd;
    sorted_rd_r <= sorted_mem[sym_ra];
    if (cw_we) begin
      code_mem[cw_wa] <= code_wd;
      size_mem[cw_wa] <= size_wd;
    end
    code_rd_r <= code_mem[cw_ra];
    size_rd_r <= size_mem[cw_ra];
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    pop           = 1'b0;
    sym_we        = 1'b0;
    sym_wa        = sweep_r;
    sym_wd        = '0;
    sym_ra        = pos_r;
    cw_we         = 1'b0;
    cw_wa         = sweep_r;
    cw_ra         = AW'(head.symbol);
    code_wd       = '0;
    size_wd       = '0;
    cnt_we        = 1'b0;
    mm_init       = 1'b0;
    min_we        = 1'b0;
    max_we        = 1'b0;
    sweep_nxt     = sweep_r;
    any_nxt       = any_r;
    acc_nxt       = acc_r;
    bt_nxt        = bt_r;
    off_nxt       = off_r;
    len_nxt       = len_r;
    k_nxt         = k_r;
    pos_nxt       = pos_r;
    code_nxt      = code_r;
    out_valid_nxt = out_valid_r && out_stall;
    kind_nxt      = kind_r;
    osym_nxt      = osym_r;
    ocode_nxt     = ocode_r;
    osize_nxt     = osize_r;

    unique case (state_r)
      // Clear the symbol memories after reset
      ST_INIT: begin
        sym_we = 1'b1;
        cw_we  = 1'b1;
        if (sweep_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end else begin
          sweep_nxt = sweep_r + AW'(1);
        end
      end

      ST_IDLE: begin
        if (!q_stat.empty && !out_valid_r) begin
          pop = 1'b1;
          unique case (head.op)
            CMD_LOAD_COUNT: cnt_we = 1'b1;
            CMD_LOAD_SYMBOL: begin
              sym_we = 1'b1;
              sym_wa = AW'(head.table_index);
              sym_wd = head.symbol;
            end
            CMD_RANGE_ERR: begin
              out_valid_nxt = 1'b1;
              kind_nxt      = KIND_RANGE;
              osym_nxt      = '0;
              ocode_nxt     = '0;
              osize_nxt     = '0;
            end
            CMD_BUILD: begin
              mm_init   = 1'b1;
              any_nxt   = 1'b0;
              sweep_nxt = '0;
              state_nxt = ST_BCLR;
            end
            CMD_ENCODE: begin
              if (32'(head.symbol) < 32'(NUM_SYMBOLS)) begin
                state_nxt = ST_ENC_RD;
              end else begin
                out_valid_nxt = 1'b1;
                kind_nxt      = KIND_NO_CODE;
                osym_nxt      = '0;
                ocode_nxt     = '0;
                osize_nxt     = '0;
              end
            end
            CMD_DECODE: begin
              osym_nxt  = '0;
              ocode_nxt = '0;
              osize_nxt = '0;
              kind_nxt  = KIND_INVALID;
              if (!any_r) begin
                out_valid_nxt = 1'b1;
                acc_nxt       = '0;
                bt_nxt        = '0;
                off_nxt       = '0;
              end else if (cnt_len != '0 && hit) begin
                // code matched: clear decoder, fetch the symbol if the index is in range
                acc_nxt = '0;
                bt_nxt  = '0;
                off_nxt = '0;
                if (idx_w >= 32'(NUM_SYMBOLS)) begin
                  out_valid_nxt = 1'b1;
                end else begin
                  sym_ra    = AW'(idx_w);
                  state_nxt = ST_DEC_RD;
                end
              end else if (bt_inc >= BT_MAX) begin
                out_valid_nxt = 1'b1;
                acc_nxt       = '0;
                bt_nxt        = '0;
                off_nxt       = '0;
              end else begin
                acc_nxt = acc_sh;
                bt_nxt  = bt_inc;
                if (cnt_len != '0) off_nxt = off_add;
              end
            end
            default: ;
          endcase
        end
      end

      // Build: wipe codes and sizes
      ST_BCLR: begin
        cw_we = 1'b1;
        if (sweep_r == LAST_ADDR) begin
          len_nxt   = LCW'(1);
          pos_nxt   = '0;
          code_nxt  = '0;
          state_nxt = ST_BLEN;
        end else begin
          sweep_nxt = sweep_r + AW'(1);
        end
      end

      // Build: step to next length, start its codes, or finish
      ST_BLEN: begin
        if (len_r == LEN_END) begin
          acc_nxt   = '0;
          bt_nxt    = '0;
          off_nxt   = '0;
          state_nxt = ST_IDLE;
        end else if (n_cur != '0) begin
          any_nxt   = 1'b1;
          k_nxt     = '0;
          state_nxt = ST_BCODE;
        end else begin
          code_nxt = {code_r[CODE_W-2:0], 1'b0};
          len_nxt  = len_r + LCW'(1);
        end
      end

      // Build: one code of this length
      ST_BCODE: begin
        min_we = (k_r == '0);
        max_we = 1'b1;
        if (32'(pos_r) < 32'(NUM_SYMBOLS)) begin
          sym_ra    = pos_r;
          state_nxt = ST_BWR;
        end else begin
          k_nxt = k_r + CNT_W'(1);
          if (last_k) begin
            code_nxt  = {code_inc[CODE_W-2:0], 1'b0};
            len_nxt   = len_r + LCW'(1);
            state_nxt = ST_BLEN;
          end else begin
            code_nxt = code_inc;
          end
        end
      end

      // Build: store code of the listed symbol
      ST_BWR: begin
        if (32'(sorted_rd_r) < 32'(NUM_SYMBOLS)) begin
          cw_we   = 1'b1;
          cw_wa   = AW'(sorted_rd_r);
          code_wd = code_r;
          size_wd = SIZE_W'(len_r);
        end
        pos_nxt = pos_r + AW'(1);
        k_nxt   = k_r + CNT_W'(1);
        if (last_k) begin
          code_nxt  = {code_inc[CODE_W-2:0], 1'b0};
          len_nxt   = len_r + LCW'(1);
          state_nxt = ST_BLEN;
        end else begin
          code_nxt  = code_inc;
          state_nxt = ST_BCODE;
        end
      end

      ST_DEC_RD: begin
        out_valid_nxt = 1'b1;
        kind_nxt      = KIND_SYMBOL;
        osym_nxt      = sorted_rd_r;
        ocode_nxt     = '0;
        osize_nxt     = '0;
        state_nxt     = ST_IDLE;
      end

      ST_ENC_RD: begin
        out_valid_nxt = 1'b1;
        osym_nxt      = '0;
        if (size_rd_r == '0) begin
          kind_nxt  = KIND_NO_CODE;
          ocode_nxt = '0;
          osize_nxt = '0;
        end else begin
          kind_nxt  = KIND_CODE;
          ocode_nxt = code_rd_r;
          osize_nxt = size_rd_r;
        end
        state_nxt = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = kind_r;
  assign out_symbol_out  = osym_r;
  assign out_code_bits   = ocode_r;
  assign out_code_size   = osize_r;

endmodule
`default_nettype wire

// ===== src/canonical_huffman_codec.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Canonical (JPEG-style) Huffman table engine with a bit-serial decoder and a
// symbol encoder. A front stage classifies each item and parks those it keeps
// in a two-entry queue; the back engine executes them and holds each result
// in an output register. The engine starts a new item only once the output
// register is empty. Encode and a matched decode pass through a read state
// for the registered symbol memory read. A build clears the code memory,
// then steps through the lengths and stores the code of each listed symbol.
// After reset the engine clears its symbol memories before it takes the first
// item.
module canonical_huffman_codec #(
  parameter int SYMBOL_BITS     = 8,
  parameter int MAX_CODE_LENGTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [chc_pkg::OPC_W-1:0]  in_opcode,
  input  logic [chc_pkg::LEN_W-1:0]  in_code_length,
  input  logic [chc_pkg::CNT_W-1:0]  in_length_count,
  input  logic [chc_pkg::IDX_W-1:0]  in_table_index,
  input  logic [chc_pkg::SYM_W-1:0]  in_symbol,
  input  logic                       in_bit_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [chc_pkg::KIND_W-1:0] out_result_kind,
  output logic [chc_pkg::SYM_W-1:0]  out_symbol_out,
  output logic [chc_pkg::CODE_W-1:0] out_code_bits,
  output logic [chc_pkg::SIZE_W-1:0] out_code_size
);
  import chc_pkg::*;

  cmd_t       f_cmd;
  logic       f_keep;
  logic       push;
  logic       pop;
  cmd_t       q_head;
  fifo_stat_t q_stat;

  chc_front #(
    .SYMBOL_BITS    (SYMBOL_BITS),
    .MAX_CODE_LENGTH(MAX_CODE_LENGTH)
  ) u_front (
    .opcode      (in_opcode),
    .code_length (in_code_length),
    .length_count(in_length_count),
    .table_index (in_table_index),
    .symbol      (in_symbol),
    .bit_in      (in_bit_in),
    .keep        (f_keep),
    .cmd         (f_cmd)
  );

  // Item accepted into the queue
  assign in_stall = q_stat.full;
  assign push     = in_valid && !in_stall && f_keep;

  chc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(f_cmd),
    .pop      (pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  chc_engine #(
    .SYMBOL_BITS    (SYMBOL_BITS),
    .MAX_CODE_LENGTH(MAX_CODE_LENGTH)
  ) u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_head),
    .q_stat         (q_stat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result_kind(out_result_kind),
    .out_symbol_out (out_symbol_out),
    .out_code_bits  (out_code_bits),
    .out_code_size  (out_code_size)
  );

`include "canonical_huffman_codec_assert.svh"

  // engine only takes an item that is queued
  `CHC_ASSERT_NOW(a_pop_nonempty, pop, !q_stat.empty)
  // engine only starts an item with the result register free
  `CHC_ASSERT_NOW(a_pop_out_free, pop, !out_valid)
  // a taken result is never followed directly by another
  `CHC_ASSERT_NEXT(a_out_gap, out_valid && !out_stall, !out_valid)

endmodule
`default_nettype wire
